/* src/thermistor_temperature_filter_core_defines.svh */
// Assertion macros used by the thermistor filter controller.
// Define NO_ASSERTIONS to leave every check out of the build.
`ifndef THERMISTOR_TEMPERATURE_FILTER_CORE_DEFINES_SVH
`define THERMISTOR_TEMPERATURE_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTF_ASSERT(lbl, prop, msg)
`define TTF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* src/ttf_pkg.sv */
package ttf_pkg;

    localparam int OP_W  = 4;
    localparam int CNT_W = 7;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NONE  = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_PREP  = 4'd2;
    localparam op_t OP_NORM  = 4'd3;
    localparam op_t OP_SQ    = 4'd4;
    localparam op_t OP_LOGW  = 4'd5;
    localparam op_t OP_MUL   = 4'd6;
    localparam op_t OP_MULW  = 4'd7;
    localparam op_t OP_ADD1  = 4'd8;
    localparam op_t OP_ADD2  = 4'd9;
    localparam op_t OP_DIVLD = 4'd10;
    localparam op_t OP_DIV   = 4'd11;
    localparam op_t OP_TEMP  = 4'd12;
    localparam op_t OP_EMA1  = 4'd13;
    localparam op_t OP_EMA2  = 4'd14;
    localparam op_t OP_OUT   = 4'd15;

    localparam logic [CNT_W-1:0] NORM_LAST = 7'd6;
    localparam logic [CNT_W-1:0] SQ_LAST   = 7'd32;
    localparam logic [CNT_W-1:0] MUL_LAST  = 7'd5;
    localparam logic [CNT_W-1:0] DIV_LAST  = 7'd66;
    localparam logic [2:0]       MSEL_LN   = 3'd0;
    localparam logic [2:0]       MSEL_L2   = 3'd1;
    localparam logic [2:0]       MSEL_L3   = 3'd2;
    localparam logic [2:0]       MSEL_B    = 3'd3;
    localparam logic [2:0]       MSEL_C    = 3'd4;

    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R1        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_C   = 3'd6;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [42:0] KELVIN_Q10 = 43'sd279706;
    localparam logic signed [19:0] TEMP_MAX = 20'sd524287;
    localparam logic signed [19:0] TEMP_MIN = -20'sd524288;
    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic              high_side;
        logic signed [11:0] offset;
        logic [16:0]       gain;
        logic [21:0]       r1;
        logic signed [47:0] coeff_a;
        logic signed [47:0] coeff_b;
        logic signed [47:0] coeff_c;
    } ttf_cfg_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
        logic             lsel;
        logic [2:0]       msel;
    } ttf_cmd_t;

    typedef struct packed {
        logic fault;
    } ttf_stat_t;

endpackage

/* src/ttf_ctrl.sv */
`include "thermistor_temperature_filter_core_defines.svh"

module ttf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ttf_pkg::ttf_stat_t stat,
    output ttf_pkg::ttf_cmd_t  cmd
);
    import ttf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_NORM  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_LOGW  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_MULW  = 4'd7;
    localparam logic [3:0] ST_ADD1  = 4'd8;
    localparam logic [3:0] ST_ADD2  = 4'd9;
    localparam logic [3:0] ST_DIVLD = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_TEMP  = 4'd12;
    localparam logic [3:0] ST_EMA1  = 4'd13;
    localparam logic [3:0] ST_EMA2  = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             lsel_reg, lsel_next;
    logic [2:0]       msel_reg, msel_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lsel_next      = lsel_reg;
        msel_next      = msel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.cnt        = cnt_reg;
        cmd.lsel       = lsel_reg;
        cmd.msel       = msel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.fault ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                cnt_next   = '0;
                lsel_next  = 1'b0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.op = OP_NORM;
                if (cnt_reg == NORM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOGW;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_LOGW:
            begin
                cmd.op = OP_LOGW;
                if (lsel_reg)
                begin
                    msel_next  = MSEL_LN;
                    state_next = ST_MUL;
                end
                else
                begin
                    lsel_next  = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MULW;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_MULW:
            begin
                cmd.op = OP_MULW;
                if (msel_reg == MSEL_C)
                begin
                    state_next = ST_ADD1;
                end
                else
                begin
                    msel_next  = msel_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_ADD1:
            begin
                cmd.op     = OP_ADD1;
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                cmd.op     = OP_ADD2;
                state_next = ST_DIVLD;
            end
            ST_DIVLD:
            begin
                cmd.op     = OP_DIVLD;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_TEMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_TEMP:
            begin
                cmd.op     = OP_TEMP;
                state_next = ST_EMA1;
            end
            ST_EMA1:
            begin
                cmd.op     = OP_EMA1;
                state_next = ST_EMA2;
            end
            ST_EMA2:
            begin
                cmd.op     = OP_EMA2;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result register must be free before it is overwritten.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lsel_reg      <= 1'b0;
            msel_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lsel_reg      <= lsel_next;
            msel_reg      <= msel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TTF_ASSERT_RST(a_reset_idle, !rst_n |=> (state_reg == ST_IDLE && !out_valid_reg), "reset not idle")
    `TTF_ASSERT(a_accept_check, (in_valid && in_ready) |=> (state_reg == ST_CHECK), "accept lost")
    `TTF_ASSERT(a_done_holds, (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE && out_valid_reg), "result overwritten")
    `TTF_ASSERT(a_div_bound, (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST), "divider overran")
    `TTF_ASSERT(a_done_to_idle, (state_reg == ST_DONE && (!out_valid_reg || out_ready)) |=> (state_reg == ST_IDLE && out_valid_reg), "result not issued")

endmodule

/* src/ttf_dp.sv */
module ttf_dp #(
    parameter int ADC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ttf_pkg::ttf_cmd_t   cmd,
    input  ttf_pkg::ttf_cfg_t   cfg,
    input  logic [ADC_BITS-1:0] adc_sample,
    output ttf_pkg::ttf_stat_t  stat,
    output logic signed [19:0]  smoothed_temp,
    output logic signed [19:0]  instant_temp,
    output logic                conversion_fault
);
    import ttf_pkg::*;

    localparam int XW    = (ADC_BITS > 12 ? ADC_BITS : 12) + 2;
    localparam int NUM_W = 22 + ADC_BITS;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        mag64 = a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? INT64_MIN : INT64_MAX;
        else
            sat_add = s[63:0];
    endfunction

    logic [ADC_BITS-1:0] xu_reg, xu_next;
    logic                fault_reg, fault_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [ADC_BITS-1:0] den_reg, den_next;
    logic [63:0]         nrm_reg, nrm_next;
    logic [5:0]          sh_reg, sh_next;
    logic [31:0]         m_reg, m_next;
    logic [31:0]         f_reg, f_next;
    logic [37:0]         lga_reg, lga_next;
    logic signed [38:0]  d_reg, d_next;
    logic [63:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic [63:0]         pp_reg, pp_next;
    logic [1:0]          psh_reg, psh_next;
    logic [127:0]        acc_reg, acc_next;
    logic signed [63:0]  lnr_reg, lnr_next, l2_reg, l2_next, l3_reg, l3_next;
    logic signed [63:0]  pb_reg, pb_next, pc_reg, pc_next, y_reg, y_next;
    logic [63:0]         ay_reg, ay_next;
    logic                small_reg, small_next, yneg_reg, yneg_next;
    logic [63:0]         rem_reg, rem_next;
    logic [40:0]         q_reg, q_next;
    logic signed [19:0]  t_reg, t_next;
    logic signed [50:0]  prod_reg, prod_next;
    logic signed [31:0]  avg_reg, avg_next;
    logic signed [19:0]  so_reg, so_next, io_reg, io_next;
    logic                fo_reg, fo_next;

    logic signed [XW-1:0] x;
    logic signed [XW-1:0] full_s;
    logic [ADC_BITS-1:0]  fmx;
    logic [21:0]          r1e;
    logic [5:0]           amt;
    logic [6:0]           rsh;
    logic [63:0]          sq;
    logic [32:0]          sq_t;
    logic [37:0]          lg;
    logic signed [63:0]   mop_a, mop_b, mres;
    logic [2:0]           k;
    logic [31:0]          ah, bh;
    logic [63:0]          r_mul;
    logic [64:0]          rs;
    logic signed [42:0]   qs, tk;
    logic [16:0]          ge;
    logic signed [17:0]   gs;
    logic signed [32:0]   diff;
    logic signed [50:0]   rnd;
    logic signed [34:0]   inc;

    assign full_s = $signed({{(XW-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}});
    assign x = $signed({{(XW-ADC_BITS){1'b0}}, adc_sample})
             + $signed({{(XW-12){cfg.offset[11]}}, cfg.offset});
    assign fmx = {ADC_BITS{1'b1}} - xu_reg;
    assign r1e = (cfg.r1 == 22'd0) ? 22'd1 : cfg.r1;
    assign lg  = {6'd63 - sh_reg, f_reg};
    assign k   = cmd.cnt[2:0] - 3'd1;

    assign stat.fault       = fault_reg;
    assign smoothed_temp    = so_reg;
    assign instant_temp     = io_reg;
    assign conversion_fault = fo_reg;

    always_comb
    begin
        case (cmd.cnt[2:0])
            3'd1:    amt = 6'd32;
            3'd2:    amt = 6'd16;
            3'd3:    amt = 6'd8;
            3'd4:    amt = 6'd4;
            3'd5:    amt = 6'd2;
            default: amt = 6'd1;
        endcase
        rsh  = 7'd64 - {1'b0, amt};
        sq   = m_reg * m_reg;
        sq_t = sq[63:31];

        case (cmd.msel)
            MSEL_LN: begin mop_a = {{25{d_reg[38]}}, d_reg}; mop_b = {32'd0, LN2_Q32}; end
            MSEL_L2: begin mop_a = lnr_reg; mop_b = lnr_reg; end
            MSEL_L3: begin mop_a = l2_reg; mop_b = lnr_reg; end
            MSEL_B:  begin mop_a = {{16{cfg.coeff_b[47]}}, cfg.coeff_b}; mop_b = lnr_reg; end
            default: begin mop_a = {{16{cfg.coeff_c[47]}}, cfg.coeff_c}; mop_b = l3_reg; end
        endcase
        ah = k[1] ? ma_reg[63:32] : ma_reg[31:0];
        bh = k[0] ? mb_reg[63:32] : mb_reg[31:0];

        // Product scaled by 2^-32; anything at or above 2^63 saturates.
        r_mul = acc_reg[95:32];
        if (|acc_reg[127:95])
            mres = INT64_MAX;
        else
            mres = $signed(r_mul);
        if (neg_reg)
            mres = -mres;

        rs = {rem_reg, (cmd.cnt == 7'd0)};
        qs = yneg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        tk = qs - KELVIN_Q10;

        ge   = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
        gs   = $signed({1'b0, ge});
        diff = {{13{t_reg[19]}}, t_reg} - {avg_reg[31], avg_reg};
        rnd  = prod_reg + 51'sd32768;
        inc  = 35'(rnd >>> 16);

        xu_next = xu_reg;  fault_next = fault_reg;
        num_next = num_reg; den_next = den_reg;
        nrm_next = nrm_reg; sh_next = sh_reg; m_next = m_reg; f_next = f_reg;
        lga_next = lga_reg; d_next = d_reg;
        ma_next = ma_reg; mb_next = mb_reg; neg_next = neg_reg;
        pp_next = pp_reg; psh_next = psh_reg; acc_next = acc_reg;
        lnr_next = lnr_reg; l2_next = l2_reg; l3_next = l3_reg;
        pb_next = pb_reg; pc_next = pc_reg; y_next = y_reg;
        ay_next = ay_reg; small_next = small_reg; yneg_next = yneg_reg;
        rem_next = rem_reg; q_next = q_reg; t_next = t_reg;
        prod_next = prod_reg; avg_next = avg_reg;
        so_next = so_reg; io_next = io_reg; fo_next = fo_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                fault_next = (x <= 0) || (x >= full_s);
                xu_next    = x[ADC_BITS-1:0];
            end
            OP_PREP:
            begin
                num_next = r1e * (cfg.high_side ? fmx : xu_reg);
                den_next = cfg.high_side ? xu_reg : fmx;
            end
            OP_NORM:
            begin
                if (cmd.cnt == 7'd0)
                begin
                    nrm_next = cmd.lsel ? 64'(den_reg) : 64'(num_reg);
                    sh_next  = '0;
                end
                else if ((nrm_reg >> rsh) == 64'd0)
                begin
                    nrm_next = nrm_reg << amt;
                    sh_next  = sh_reg + amt;
                end
            end
            OP_SQ:
            begin
                if (cmd.cnt == 7'd0)
                begin
                    m_next = nrm_reg[63:32];
                    f_next = '0;
                end
                else if (sq_t[32])
                begin
                    m_next = sq_t[32:1];
                    f_next = {f_reg[30:0], 1'b1};
                end
                else
                begin
                    m_next = sq_t[31:0];
                    f_next = {f_reg[30:0], 1'b0};
                end
            end
            OP_LOGW:
            begin
                if (cmd.lsel)
                    d_next = $signed({1'b0, lga_reg}) - $signed({1'b0, lg});
                else
                    lga_next = lg;
            end
            OP_MUL:
            begin
                if (cmd.cnt == 7'd0)
                begin
                    ma_next  = mag64(mop_a);
                    mb_next  = mag64(mop_b);
                    neg_next = mop_a[63] ^ mop_b[63];
                    acc_next = '0;
                end
                else
                begin
                    // Four 32x32 partial products; each is registered and added in the next cycle.
                    if (k < 3'd4)
                    begin
                        pp_next  = ah * bh;
                        psh_next = {1'b0, k[1]} + {1'b0, k[0]};
                    end
                    if (k != 3'd0)
                        acc_next = acc_reg + ({64'd0, pp_reg} << {psh_reg, 5'd0});
                end
            end
            OP_MULW:
            begin
                case (cmd.msel)
                    MSEL_LN: lnr_next = mres;
                    MSEL_L2: l2_next  = mres;
                    MSEL_L3: l3_next  = mres;
                    MSEL_B:  pb_next  = mres;
                    default: pc_next  = mres;
                endcase
            end
            OP_ADD1:
            begin
                y_next = sat_add({{16{cfg.coeff_a[47]}}, cfg.coeff_a}, pb_reg);
            end
            OP_ADD2:
            begin
                y_next = sat_add(y_reg, pc_reg);
            end
            OP_DIVLD:
            begin
                ay_next    = mag64(y_reg);
                small_next = (mag64(y_reg) >> 26) == 64'd0;
                yneg_next  = y_reg[63];
                rem_next   = '0;
                q_next     = '0;
            end
            OP_DIV:
            begin
                if (rs >= {1'b0, ay_reg})
                begin
                    rem_next = 64'(rs - {1'b0, ay_reg});
                    q_next   = {q_reg[39:0], 1'b1};
                end
                else
                begin
                    rem_next = rs[63:0];
                    q_next   = {q_reg[39:0], 1'b0};
                end
            end
            OP_TEMP:
            begin
                if (small_reg)
                    t_next = yneg_reg ? TEMP_MIN : TEMP_MAX;
                else if (tk > 43'(TEMP_MAX))
                    t_next = TEMP_MAX;
                else if (tk < 43'(TEMP_MIN))
                    t_next = TEMP_MIN;
                else
                    t_next = tk[19:0];
            end
            OP_EMA1:
            begin
                prod_next = diff * gs;
            end
            OP_EMA2:
            begin
                avg_next = avg_reg + $signed(inc[31:0]);
            end
            OP_OUT:
            begin
                so_next = avg_reg[19:0];
                io_next = fault_reg ? 20'sd0 : t_reg;
                fo_next = fault_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        xu_reg <= xu_next;  fault_reg <= fault_next;
        num_reg <= num_next; den_reg <= den_next;
        nrm_reg <= nrm_next; sh_reg <= sh_next; m_reg <= m_next; f_reg <= f_next;
        lga_reg <= lga_next; d_reg <= d_next;
        ma_reg <= ma_next; mb_reg <= mb_next; neg_reg <= neg_next;
        pp_reg <= pp_next; psh_reg <= psh_next; acc_reg <= acc_next;
        lnr_reg <= lnr_next; l2_reg <= l2_next; l3_reg <= l3_next;
        pb_reg <= pb_next; pc_reg <= pc_next; y_reg <= y_next;
        ay_reg <= ay_next; small_reg <= small_next; yneg_reg <= yneg_next;
        rem_reg <= rem_next; q_reg <= q_next; t_reg <= t_next;
        prod_reg <= prod_next;
        so_reg <= so_next; io_reg <= io_next; fo_reg <= fo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avg_reg <= '0;
        else
            avg_reg <= avg_next;
    end

endmodule

/* src/thermistor_temperature_filter_core.sv */
// An accepted sample runs the log, multiply, divide and filter states to its result beat; a
// faulted one skips to the result. A new sample is taken only once a result is issued, paced
// by the 67-step restoring divider and the two 32-step log2 squaring loops that share the controller.
// The result register frees the input side while a finished beat waits to be taken.
// Reset clears the controller, the average (to zero) and loads the register defaults.
module thermistor_temperature_filter_core #(
    parameter int ADC_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ADC_BITS-1:0]         adc_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [19:0]          smoothed_temp,
    output logic signed [19:0]          instant_temp,
    output logic                        conversion_fault,
    input  logic                        cfg_we,
    input  logic [ttf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttf_pkg::CFG_W-1:0]   cfg_wdata
);
    import ttf_pkg::*;

    logic               high_side_reg;
    logic signed [11:0] offset_reg;
    logic [16:0]        gain_reg;
    logic [21:0]        r1_reg;
    logic signed [47:0] coeff_a_reg, coeff_b_reg, coeff_c_reg;

    ttf_cfg_t  cfg;
    ttf_cmd_t  cmd;
    ttf_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_side_reg <= 1'b0;
            offset_reg    <= '0;
            gain_reg      <= 17'd6554;
            r1_reg        <= 22'd10000;
            coeff_a_reg   <= '0;
            coeff_b_reg   <= '0;
            coeff_c_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_SIDE: high_side_reg <= cfg_wdata[0];
                CFG_OFFSET:    offset_reg    <= cfg_wdata[11:0];
                CFG_GAIN:      gain_reg      <= cfg_wdata[16:0];
                CFG_R1:        r1_reg        <= cfg_wdata[21:0];
                CFG_COEFF_A:   coeff_a_reg   <= cfg_wdata[47:0];
                CFG_COEFF_B:   coeff_b_reg   <= cfg_wdata[47:0];
                CFG_COEFF_C:   coeff_c_reg   <= cfg_wdata[47:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.high_side = high_side_reg;
    assign cfg.offset    = offset_reg;
    assign cfg.gain      = gain_reg;
    assign cfg.r1        = r1_reg;
    assign cfg.coeff_a   = coeff_a_reg;
    assign cfg.coeff_b   = coeff_b_reg;
    assign cfg.coeff_c   = coeff_c_reg;

    ttf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ttf_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg),
        .adc_sample       (adc_sample),
        .stat             (stat),
        .smoothed_temp    (smoothed_temp),
        .instant_temp     (instant_temp),
        .conversion_fault (conversion_fault)
    );

endmodule

/* verif/thermistor_filter_checker.sv */
module thermistor_filter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [11:0]                     adc_sample,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [19:0]              smoothed_temp,
    input  logic signed [19:0]              instant_temp,
    input  logic                            conversion_fault,
    input  logic                            cfg_we,
    input  logic [ttf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttf_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              mismatches,
    output int                              pending
);
    import ttf_pkg::*;

    typedef struct packed {
        logic signed [19:0] smoothed;
        logic signed [19:0] instant;
        logic               fault;
    } temp_result_t;

    localparam logic signed [63:0] ADC_FULL = 64'sd4095;

    ttf_cfg_t           cfg;
    logic signed [31:0] avg_temp;
    temp_result_t       expected_temps[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    // Product shifted right by sh, truncated toward zero and saturated.
    function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic [127:0] prod;
        logic [127:0] r;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        r    = prod >> sh;
        if (r > {64'd0, INT64_MAX})
            r = {64'd0, INT64_MAX};
        return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        if (b > 0 && a > INT64_MAX - b)
            return INT64_MAX;
        if (b < 0 && a < INT64_MIN - b)
            return INT64_MIN;
        return a + b;
    endfunction

    function automatic logic signed [63:0] log2_q32(input logic [63:0] n);
        int          p;
        logic [63:0] m;
        logic [31:0] f;
        p = 0;
        while (p < 63 && (n >> (p + 1)) != 0)
            p++;
        m = (p > 31) ? (n >> (p - 31)) : (n << (31 - p));
        f = '0;
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            f = {f[30:0], 1'b0};
            if (m >= 64'h1_0000_0000)
            begin
                m    = m >> 1;
                f[0] = 1'b1;
            end
        end
        return {p[31:0], f};
    endfunction

    function automatic logic [63:0] recip_2p66(input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int bitpos = 66; bitpos >= 0; bitpos--)
        begin
            rem = {rem[62:0], bitpos == 66};
            q   = q << 1;
            if (rem >= d)
            begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic temp_result_t convert_sample(input logic [11:0] raw);
        temp_result_t       res;
        logic signed [63:0] x, lnr, l2, l3, y, t, diff, gain, step;
        logic [63:0]        r1, num, den, ay;
        x  = $signed({52'd0, raw}) + 64'(cfg.offset);
        r1 = (cfg.r1 == 0) ? 64'd1 : 64'(cfg.r1);
        if (x <= 0 || x >= ADC_FULL)
        begin
            res.smoothed = avg_temp[19:0];
            res.instant  = '0;
            res.fault    = 1'b1;
            return res;
        end
        if (cfg.high_side)
        begin
            num = r1 * (ADC_FULL - x);
            den = x;
        end
        else
        begin
            num = r1 * x;
            den = ADC_FULL - x;
        end
        lnr = mul_shift(log2_q32(num) - log2_q32(den), {32'd0, LN2_Q32}, 32);
        l2  = mul_shift(lnr, lnr, 32);
        l3  = mul_shift(l2, lnr, 32);
        y   = sat_add(sat_add(64'(cfg.coeff_a), mul_shift(64'(cfg.coeff_b), lnr, 32)),
                      mul_shift(64'(cfg.coeff_c), l3, 32));
        ay  = magnitude(y);
        if (ay < 64'd1 << 26)
            t = (y >= 0) ? 64'(TEMP_MAX) : 64'(TEMP_MIN);
        else
        begin
            t = (y >= 0 ? $signed(recip_2p66(ay)) : -$signed(recip_2p66(ay))) - KELVIN_Q10;
            if (t > TEMP_MAX)
                t = TEMP_MAX;
            if (t < TEMP_MIN)
                t = TEMP_MIN;
        end
        gain     = (cfg.gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(cfg.gain);
        diff     = t - 64'(avg_temp);
        step     = (diff * gain + 64'sd32768) >>> 16;
        avg_temp = 32'(64'(avg_temp) + step);
        res.smoothed = avg_temp[19:0];
        res.instant  = t[19:0];
        res.fault    = 1'b0;
        return res;
    endfunction

    assign pending = expected_temps.size();

    always @(posedge clk or negedge rst_n)
    begin
        temp_result_t want;
        if (!rst_n)
        begin
            cfg        <= '{high_side: 1'b0, offset: '0, gain: 17'd6554, r1: 22'd10000,
                            coeff_a: '0, coeff_b: '0, coeff_c: '0};
            avg_temp   = '0;
            mismatches <= 0;
            expected_temps.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_temps.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (want.smoothed !== smoothed_temp || want.instant !== instant_temp ||
                        want.fault !== conversion_fault)
                    begin
                        $display("%0t: mismatch expected smoothed=%0d instant=%0d fault=%0b",
                                 $time, want.smoothed, want.instant, want.fault);
                        $display("%0t:          actual   smoothed=%0d instant=%0d fault=%0b",
                                 $time, smoothed_temp, instant_temp, conversion_fault);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_temps.push_back(convert_sample(adc_sample));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HIGH_SIDE: cfg.high_side <= cfg_wdata[0];
                    CFG_OFFSET:    cfg.offset    <= cfg_wdata[11:0];
                    CFG_GAIN:      cfg.gain      <= cfg_wdata[16:0];
                    CFG_R1:        cfg.r1        <= cfg_wdata[21:0];
                    CFG_COEFF_A:   cfg.coeff_a   <= cfg_wdata[47:0];
                    CFG_COEFF_B:   cfg.coeff_b   <= cfg_wdata[47:0];
                    CFG_COEFF_C:   cfg.coeff_c   <= cfg_wdata[47:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

/* verif/tb_thermistor_temperature_filter_core.sv */
module tb_thermistor_temperature_filter_core;
    import ttf_pkg::*;

    // Typical 10k NTC constants expressed in units of 2^-56.
    localparam logic signed [47:0] NTC_A = 48'sd81353000000000;
    localparam logic signed [47:0] NTC_B = 48'sd16869000000000;
    localparam logic signed [47:0] NTC_C = 48'sd6323000000;
    localparam int                 STALL_LIMIT = 20000;
    // An index past the end of the register list; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [11:0]            adc_sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [19:0]     smoothed_temp;
    logic signed [19:0]     instant_temp;
    logic                   conversion_fault;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    int                     mismatches;
    int                     pending;
    int                     idle_cycles = 0;

    always #4 clk = ~clk;

    thermistor_temperature_filter_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .smoothed_temp(smoothed_temp), .instant_temp(instant_temp),
        .conversion_fault(conversion_fault),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    thermistor_filter_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .smoothed_temp(smoothed_temp), .instant_temp(instant_temp),
        .conversion_fault(conversion_fault),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .pending(pending)
    );

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    always @(negedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            stall = gap_cycles();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(input logic high_side, input logic signed [11:0] offset,
                             input logic [16:0] gain, input logic [21:0] r1,
                             input logic signed [47:0] ca, input logic signed [47:0] cb,
                             input logic signed [47:0] cc);
        write_reg(CFG_HIGH_SIDE, CFG_W'(high_side));
        write_reg(CFG_OFFSET, CFG_W'($unsigned(offset)));
        write_reg(CFG_GAIN, CFG_W'(gain));
        write_reg(CFG_R1, CFG_W'(r1));
        write_reg(CFG_COEFF_A, ca);
        write_reg(CFG_COEFF_B, cb);
        write_reg(CFG_COEFF_C, cc);
    endtask

    // Called on a falling edge; returns on the falling edge after acceptance.
    task automatic send_sample(input logic [11:0] value);
        int gap;
        gap = gap_cycles();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= value;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [11:0] random_sample();
        if ($urandom_range(9) == 0)
            return 12'($urandom_range(0, 40)) | ($urandom_range(1) ? 12'hFC0 : 12'h000);
        return 12'($urandom);
    endfunction

    function automatic logic signed [47:0] jitter(input logic signed [47:0] v);
        return v + 48'($signed($urandom_range(0, 2000000)) - 1000000) * 48'sd1000;
    endfunction

    initial
    begin
        logic signed [11:0] offset;
        logic [16:0]        gain;
        logic [21:0]        r1;
        int                 count;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: zero coefficients drive the reciprocal into saturation.
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd4094);
        send_sample(12'd2048);
        drain();

        // Realistic divider, then the offset extremes and a negative tiny sum.
        write_all(1'b0, 12'sd0, 17'd65536, 22'd10000, NTC_A, NTC_B, NTC_C);
        write_reg(CFG_SPARE_IDX, 48'hFFFF_FFFF_FFFF);
        send_sample(12'd1);
        send_sample(12'd4094);
        send_sample(12'd2047);
        send_sample(12'd3000);
        drain();
        write_all(1'b1, 12'sd0, 17'd0, 22'd0, NTC_A, NTC_B, NTC_C);
        send_sample(12'd1000);
        send_sample(12'd100);
        drain();
        write_all(1'b1, -12'sd2048, 17'h1FFFF, 22'h3FFFFF, -48'sd1000, 48'sd0, 48'sd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd3000);
        drain();
        write_all(1'b0, 12'sd2047, 17'd32768, 22'd1, 48'sh7FFF_FFFF_FFFF,
                  48'sh8000_0000_0000, 48'sh8000_0000_0000);
        send_sample(12'd0);
        send_sample(12'd2047);
        send_sample(12'd1000);
        send_sample(12'd1);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            offset = (phase % 4 == 3) ? 12'($urandom) : 12'($signed($urandom_range(0, 60)) - 30);
            gain   = (phase % 5 == 4) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            r1     = (phase % 3 == 2) ? 22'($urandom_range(1, 4194303))
                                      : 22'($urandom_range(1000, 100000));
            if (phase % 4 == 1)
                write_all(1'($urandom_range(1)), offset, gain, r1,
                          48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          48'({$urandom, $urandom}));
            else
                write_all(1'($urandom_range(1)), offset, gain, r1,
                          jitter(NTC_A), jitter(NTC_B), 48'(NTC_C + $urandom_range(0, 1 << 30)));
            count = $urandom_range(100, 180);
            for (int i = 0; i < count; i++)
                send_sample(random_sample());
            drain();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
